[src/rqe_pkg.sv]
`timescale 1ns / 1ps

package rqe_pkg;

  localparam int NUM_LEVELS = 8;
  localparam int NUM_SLOTS  = 32;

  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam int SLOT_W = $clog2(NUM_SLOTS);
  // one more bit so the null marker (NUM_SLOTS) fits
  localparam int LINK_W = $clog2(NUM_SLOTS + 1);

  typedef logic [LVL_W-1:0]  lvl_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [LINK_W-1:0] link_t;
  typedef logic [1:0]        mode_t;
  typedef logic [1:0]        status_t;

  localparam link_t LINK_NIL = LINK_W'(NUM_SLOTS);

  localparam mode_t MODE_APPEND = 2'd0;
  localparam mode_t MODE_INSERT = 2'd1;
  localparam mode_t MODE_POP    = 2'd2;
  localparam mode_t MODE_REMOVE = 2'd3;

  localparam status_t ST_DONE      = 2'd0;
  localparam status_t ST_EMPTY     = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_QUEUED    = 2'd3;

  // write request into the slot table
  typedef struct packed {
    logic  wr_next;
    logic  wr_mark;
    slot_t addr;
    link_t next_val;
    logic  mark_val;
  } wr_req_t;

  // finished item handed to the output register
  typedef struct packed {
    logic    load;
    slot_t   popped_slot;
    status_t status;
  } reply_t;

  function automatic logic link_ok(input link_t v);
    return v < LINK_NIL;
  endfunction

endpackage

[src/priority_ready_queue_engine_top.sv]
`timescale 1ns / 1ps

// Multilevel ready queue: one linked FIFO of slot numbers per priority level
// over a shared slot table with a single next-link read port. Items run one
// at a time: in_stall stays high from acceptance until the result is loaded
// into the output register. Append, insert and pop pass through decode and
// at most one further state before the reply; remove walks its list from the
// head, one link followed per cycle, and then detaches the found slot.
// A not-found remove replies once the walk has passed the end of the list. The
// next item can be accepted while the previous result still waits on out_stall.
module priority_ready_queue_engine_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  rqe_pkg::mode_t    mode,
  input  rqe_pkg::lvl_t     level,
  input  rqe_pkg::slot_t    slot,
  output logic              out_valid,
  input  logic              out_stall,
  output rqe_pkg::slot_t    popped_slot,
  output rqe_pkg::status_t  status
);
  import rqe_pkg::*;

  logic    acc, busy, res_free, mark_rd;
  slot_t   next_addr, mark_addr;
  link_t   next_rd;
  wr_req_t wr;
  reply_t  rep;

  assign in_stall = busy;
  assign acc      = in_valid && !in_stall;
  assign res_free = !out_valid || !out_stall;

  rqe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .mode      (mode),
    .level     (level),
    .slot      (slot),
    .res_free  (res_free),
    .next_rd   (next_rd),
    .mark_rd   (mark_rd),
    .next_addr (next_addr),
    .mark_addr (mark_addr),
    .wr        (wr),
    .rep       (rep),
    .busy      (busy)
  );

  rqe_slot_table u_table (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .next_addr (next_addr),
    .next_rd   (next_rd),
    .mark_addr (mark_addr),
    .mark_rd   (mark_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rep.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rep.load) begin
      popped_slot <= rep.popped_slot;
      status      <= rep.status;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    acc |=> in_stall)
    else $error("engine not busy after accepting an item");

  a_load_into_free_reg: assert property (@(posedge clk) disable iff (rst)
    rep.load |-> !(out_valid && out_stall))
    else $error("result loaded over a pending result");

  a_load_shows_valid: assert property (@(posedge clk) disable iff (rst)
    rep.load |=> out_valid)
    else $error("loaded result not presented");

  a_popped_only_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && popped_slot != '0 |-> status == ST_DONE)
    else $error("popped slot reported with a failure status");

endmodule

[src/rqe_slot_table.sv]
`timescale 1ns / 1ps

module rqe_slot_table (
  input  logic             clk,
  input  logic             rst,
  input  rqe_pkg::wr_req_t wr,
  input  rqe_pkg::slot_t   next_addr,
  output rqe_pkg::link_t   next_rd,
  input  rqe_pkg::slot_t   mark_addr,
  output logic             mark_rd
);
  import rqe_pkg::*;

  link_t                next_link [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] queued_mark;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        next_link[i] <= LINK_NIL;
      end
      queued_mark <= '0;
    end else begin
      if (wr.wr_next) begin
        next_link[wr.addr] <= wr.next_val;
      end
      if (wr.wr_mark) begin
        queued_mark[wr.addr] <= wr.mark_val;
      end
    end
  end

  assign next_rd = next_link[next_addr];
  assign mark_rd = queued_mark[mark_addr];

endmodule

[src/rqe_ctrl.sv]
`timescale 1ns / 1ps

module rqe_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             acc,
  input  rqe_pkg::mode_t   mode,
  input  rqe_pkg::lvl_t    level,
  input  rqe_pkg::slot_t   slot,
  input  logic             res_free,
  input  rqe_pkg::link_t   next_rd,
  input  logic             mark_rd,
  output rqe_pkg::slot_t   next_addr,
  output rqe_pkg::slot_t   mark_addr,
  output rqe_pkg::wr_req_t wr,
  output rqe_pkg::reply_t  rep,
  output logic             busy
);
  import rqe_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_APPEND = 3'd2;
  localparam logic [2:0] S_POP    = 3'd3;
  localparam logic [2:0] S_WALK   = 3'd4;
  localparam logic [2:0] S_DETACH = 3'd5;
  localparam logic [2:0] S_REPLY  = 3'd6;

  logic [2:0] state, state_next;
  mode_t      op_mode;
  lvl_t       op_lvl;
  slot_t      op_slot;
  link_t      cur, cur_next;
  link_t      prev, prev_next;
  link_t      steps, steps_next;
  slot_t      res_slot, res_slot_next;
  status_t    res_st, res_st_next;

  link_t head_tab [NUM_LEVELS];
  link_t tail_tab [NUM_LEVELS];

  logic  head_we, tail_we;
  link_t head_val, tail_val;
  link_t head_cur, tail_cur, slot_link;

  assign head_cur  = head_tab[op_lvl];
  assign tail_cur  = tail_tab[op_lvl];
  assign slot_link = LINK_W'(op_slot);

  assign next_addr = cur[SLOT_W-1:0];
  assign mark_addr = op_slot;
  assign busy      = (state != S_IDLE);

  assign rep.load        = (state == S_REPLY) && res_free;
  assign rep.popped_slot = res_slot;
  assign rep.status      = res_st;

  always_comb begin
    state_next    = state;
    cur_next      = cur;
    prev_next     = prev;
    steps_next    = steps;
    res_slot_next = res_slot;
    res_st_next   = res_st;
    head_we       = 1'b0;
    head_val      = head_cur;
    tail_we       = 1'b0;
    tail_val      = tail_cur;
    wr            = '0;

    unique case (state)
      S_IDLE: begin
        if (acc) state_next = S_DECODE;
      end
      S_DECODE: begin
        res_slot_next = '0;
        res_st_next   = ST_DONE;
        unique case (op_mode)
          MODE_POP: begin
            if (!link_ok(head_cur)) begin
              res_st_next = ST_EMPTY;
              state_next  = S_REPLY;
            end else begin
              cur_next   = head_cur;
              state_next = S_POP;
            end
          end
          MODE_REMOVE: begin
            cur_next   = head_cur;
            prev_next  = LINK_NIL;
            steps_next = '0;
            state_next = S_WALK;
          end
          MODE_APPEND: begin
            if (mark_rd) begin
              res_st_next = ST_QUEUED;
              state_next  = S_REPLY;
            end else if (!link_ok(head_cur) || !link_ok(tail_cur)) begin
              head_we     = 1'b1;
              head_val    = slot_link;
              tail_we     = 1'b1;
              tail_val    = slot_link;
              wr.wr_next  = 1'b1;
              wr.wr_mark  = 1'b1;
              wr.addr     = op_slot;
              wr.next_val = LINK_NIL;
              wr.mark_val = 1'b1;
              state_next  = S_REPLY;
            end else begin
              // link old tail first, terminate the new slot next cycle
              wr.wr_next  = 1'b1;
              wr.addr     = tail_cur[SLOT_W-1:0];
              wr.next_val = slot_link;
              tail_we     = 1'b1;
              tail_val    = slot_link;
              state_next  = S_APPEND;
            end
          end
          MODE_INSERT: begin
            if (mark_rd) begin
              res_st_next = ST_QUEUED;
              state_next  = S_REPLY;
            end else begin
              wr.wr_next  = 1'b1;
              wr.wr_mark  = 1'b1;
              wr.addr     = op_slot;
              wr.next_val = link_ok(head_cur) ? head_cur : LINK_NIL;
              wr.mark_val = 1'b1;
              head_we     = 1'b1;
              head_val    = slot_link;
              if (!link_ok(head_cur)) begin
                tail_we  = 1'b1;
                tail_val = slot_link;
              end
              state_next = S_REPLY;
            end
          end
        endcase
      end
      S_APPEND: begin
        wr.wr_next  = 1'b1;
        wr.wr_mark  = 1'b1;
        wr.addr     = op_slot;
        wr.next_val = LINK_NIL;
        wr.mark_val = 1'b1;
        state_next  = S_REPLY;
      end
      S_POP: begin
        head_we = 1'b1;
        if (!link_ok(next_rd)) begin
          head_val = LINK_NIL;
          tail_we  = 1'b1;
          tail_val = LINK_NIL;
        end else begin
          head_val = next_rd;
        end
        wr.wr_next    = 1'b1;
        wr.wr_mark    = 1'b1;
        wr.addr       = cur[SLOT_W-1:0];
        wr.next_val   = LINK_NIL;
        wr.mark_val   = 1'b0;
        res_slot_next = cur[SLOT_W-1:0];
        state_next    = S_REPLY;
      end
      S_WALK: begin
        if (cur == slot_link) begin
          // unlink: predecessor (or head) skips over the found slot
          if (!link_ok(prev)) begin
            head_we  = 1'b1;
            head_val = link_ok(next_rd) ? next_rd : LINK_NIL;
            if (!link_ok(next_rd)) begin
              tail_we  = 1'b1;
              tail_val = LINK_NIL;
            end
          end else begin
            wr.wr_next  = 1'b1;
            wr.addr     = prev[SLOT_W-1:0];
            wr.next_val = link_ok(next_rd) ? next_rd : LINK_NIL;
            if (!link_ok(next_rd)) begin
              tail_we  = 1'b1;
              tail_val = prev;
            end
          end
          state_next = S_DETACH;
        end else if (!link_ok(cur) || steps == LINK_W'(NUM_SLOTS)) begin
          res_st_next = ST_NOT_FOUND;
          state_next  = S_REPLY;
        end else begin
          prev_next  = cur;
          cur_next   = next_rd;
          steps_next = steps + LINK_W'(1);
        end
      end
      S_DETACH: begin
        wr.wr_next  = 1'b1;
        wr.wr_mark  = 1'b1;
        wr.addr     = cur[SLOT_W-1:0];
        wr.next_val = LINK_NIL;
        wr.mark_val = 1'b0;
        state_next  = S_REPLY;
      end
      S_REPLY: begin
        if (res_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_tab[i] <= LINK_NIL;
        tail_tab[i] <= LINK_NIL;
      end
    end else begin
      state <= state_next;
      if (head_we) head_tab[op_lvl] <= head_val;
      if (tail_we) tail_tab[op_lvl] <= tail_val;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && state == S_IDLE) begin
      op_mode <= mode;
      op_lvl  <= level;
      op_slot <= slot;
    end
    cur      <= cur_next;
    prev     <= prev_next;
    steps    <= steps_next;
    res_slot <= res_slot_next;
    res_st   <= res_st_next;
  end

endmodule

[bench/tb_priority_ready_queue_engine_top.sv]
`timescale 1ns / 1ps

module tb_priority_ready_queue_engine_top;
  import rqe_pkg::*;

  localparam int RAND_ITEMS  = 530;
  localparam int HOLD_AT     = 140;   // items sent before the long output hold
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_AT    = 330;   // sender waits for all results here
  localparam int CALM_ITEMS  = 60;    // final stretch without idling
  localparam int WDOG_LIMIT  = 4000;
  localparam int TAIL_CYCLES = 60;

  typedef struct {
    slot_t   popped;
    status_t st;
  } sched_reply_t;

  typedef struct {
    mode_t   m;
    lvl_t    l;
    slot_t   s;
    bit      typed;
    slot_t   popped;
    status_t st;
  } dir_row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    in_valid = 1'b0;
  logic    in_stall;
  mode_t   mode = MODE_APPEND;
  lvl_t    level = '0;
  slot_t   slot = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  slot_t   popped_slot;
  status_t status;

  // shadow of the ready queues
  link_t lvl_head [NUM_LEVELS];
  link_t lvl_tail [NUM_LEVELS];
  link_t slot_next [NUM_SLOTS];
  bit    slot_busy [NUM_SLOTS];

  sched_reply_t expected_replies [$];
  int  errors = 0;
  int  n_sent = 0;
  int  idle_cycles = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  calm = 1'b0;
  bit  hold_done = 1'b0;

  priority_ready_queue_engine_top u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .level       (level),
    .slot        (slot),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .popped_slot (popped_slot),
    .status      (status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void sched_clear();
    for (int i = 0; i < NUM_LEVELS; i++) begin
      lvl_head[i] = LINK_NIL;
      lvl_tail[i] = LINK_NIL;
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_next[i] = LINK_NIL;
      slot_busy[i] = 1'b0;
    end
  endfunction

  function automatic void sched_predict(input mode_t m, input lvl_t l, input slot_t s,
                                        output slot_t got, output status_t st);
    link_t h, nx, cur, prev;
    int    steps;
    got = '0;
    if (m == MODE_POP) begin
      h = lvl_head[l];
      if (h >= NUM_SLOTS) begin
        st = ST_EMPTY;
      end else begin
        nx = slot_next[h];
        if (nx >= NUM_SLOTS) begin
          lvl_head[l] = LINK_NIL;
          lvl_tail[l] = LINK_NIL;
        end else begin
          lvl_head[l] = nx;
        end
        slot_next[h] = LINK_NIL;
        slot_busy[h] = 1'b0;
        got = h[SLOT_W-1:0];
        st = ST_DONE;
      end
    end else if (m == MODE_REMOVE) begin
      cur = lvl_head[l];
      prev = LINK_NIL;
      steps = 0;
      while (cur < NUM_SLOTS && cur != s && steps < NUM_SLOTS) begin
        prev = cur;
        cur = slot_next[cur];
        steps++;
      end
      if (cur != s) begin
        st = ST_NOT_FOUND;
      end else begin
        nx = slot_next[cur];
        if (prev >= NUM_SLOTS) begin
          lvl_head[l] = nx;
          if (nx >= NUM_SLOTS) lvl_tail[l] = LINK_NIL;
        end else begin
          slot_next[prev] = nx;
          // last element gone: tail steps back
          if (nx >= NUM_SLOTS) lvl_tail[l] = prev;
        end
        slot_next[cur] = LINK_NIL;
        slot_busy[cur] = 1'b0;
        st = ST_DONE;
      end
    end else if (slot_busy[s]) begin
      st = ST_QUEUED;
    end else begin
      if (m == MODE_APPEND) begin
        if (lvl_head[l] >= NUM_SLOTS || lvl_tail[l] >= NUM_SLOTS) lvl_head[l] = s;
        else slot_next[lvl_tail[l]] = s;
        lvl_tail[l] = s;
        slot_next[s] = LINK_NIL;
      end else begin
        if (lvl_head[l] >= NUM_SLOTS) begin
          slot_next[s] = LINK_NIL;
          lvl_tail[l] = s;
        end else begin
          slot_next[s] = lvl_head[l];
        end
        lvl_head[l] = s;
      end
      slot_busy[s] = 1'b1;
      st = ST_DONE;
    end
  endfunction

  // mostly well-formed operations on live queues, some noise
  task automatic pick_item(output mode_t m, output lvl_t l, output slot_t s);
    int    n_busy, add_pct, k, i;
    slot_t free_slots [$];
    lvl_t  live_lvls [$];
    link_t cur;
    n_busy = 0;
    for (i = 0; i < NUM_SLOTS; i++) begin
      if (slot_busy[i]) n_busy++;
      else free_slots.push_back(slot_t'(i));
    end
    for (i = 0; i < NUM_LEVELS; i++)
      if (lvl_head[i] < NUM_SLOTS) live_lvls.push_back(lvl_t'(i));
    m = mode_t'($urandom_range(0, 3));
    l = lvl_t'($urandom_range(0, NUM_LEVELS - 1));
    s = slot_t'($urandom_range(0, NUM_SLOTS - 1));
    if ($urandom_range(1, 100) <= 8) return;
    add_pct = (n_busy < 6) ? 75 : (n_busy > 26) ? 25 : 50;
    if ($urandom_range(1, 100) <= add_pct) begin
      m = ($urandom_range(1, 100) <= 70) ? MODE_APPEND : MODE_INSERT;
      // crowd a few levels so lists get long
      if ($urandom_range(0, 1)) l = lvl_t'($urandom_range(0, 2));
      if (free_slots.size() != 0 && $urandom_range(1, 100) <= 90)
        s = free_slots[$urandom_range(0, free_slots.size() - 1)];
    end else begin
      m = $urandom_range(0, 1) ? MODE_POP : MODE_REMOVE;
      if (live_lvls.size() != 0 && $urandom_range(1, 100) <= 90)
        l = live_lvls[$urandom_range(0, live_lvls.size() - 1)];
      if (m == MODE_REMOVE && lvl_head[l] < NUM_SLOTS && $urandom_range(1, 100) <= 90) begin
        cur = lvl_head[l];
        k = $urandom_range(0, NUM_SLOTS - 1);
        while (k > 0 && slot_next[cur] < NUM_SLOTS) begin
          cur = slot_next[cur];
          k--;
        end
        s = cur[SLOT_W-1:0];
      end
    end
  endtask

  task automatic send_item(input mode_t m, input lvl_t l, input slot_t s, input bit typed,
                           input slot_t t_popped, input status_t t_st);
    int           gap;
    slot_t        got;
    status_t      st;
    sched_reply_t rep;
    gap = (!calm && $urandom_range(1, 100) <= send_idle_pct) ? $urandom_range(1, 7) : 0;
    if (gap != 0 || n_sent == DRAIN_AT) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (n_sent == DRAIN_AT)
        while (expected_replies.size() != 0) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    level <= l;
    slot <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sched_predict(m, l, s, got, st);
    rep.popped = typed ? t_popped : got;
    rep.st = typed ? t_st : st;
    expected_replies.push_back(rep);
    n_sent++;
  endtask

  initial begin : stimulus
    dir_row_t dir_rows [25];
    mode_t    m;
    lvl_t     l;
    slot_t    s;
    dir_rows = '{
      '{MODE_POP,    3'd0, 5'd0,  1'b1, 5'd0, ST_EMPTY},
      '{MODE_POP,    3'd7, 5'd31, 1'b1, 5'd0, ST_EMPTY},
      '{MODE_REMOVE, 3'd7, 5'd31, 1'b1, 5'd0, ST_NOT_FOUND},
      '{MODE_APPEND, 3'd0, 5'd0,  1'b1, 5'd0, ST_DONE},
      '{MODE_APPEND, 3'd0, 5'd31, 1'b1, 5'd0, ST_DONE},
      '{MODE_APPEND, 3'd7, 5'd0,  1'b1, 5'd0, ST_QUEUED},
      '{MODE_INSERT, 3'd0, 5'd31, 1'b1, 5'd0, ST_QUEUED},
      '{MODE_INSERT, 3'd0, 5'd5,  1'b0, 5'd0, ST_DONE},
      // queued, but in another level
      '{MODE_REMOVE, 3'd7, 5'd5,  1'b1, 5'd0, ST_NOT_FOUND},
      '{MODE_APPEND, 3'd7, 5'd10, 1'b0, 5'd0, ST_DONE},
      '{MODE_INSERT, 3'd7, 5'd20, 1'b0, 5'd0, ST_DONE},
      '{MODE_REMOVE, 3'd0, 5'd31, 1'b0, 5'd0, ST_DONE},
      '{MODE_APPEND, 3'd0, 5'd12, 1'b0, 5'd0, ST_DONE},
      '{MODE_POP,    3'd0, 5'd0,  1'b0, 5'd0, ST_DONE},
      '{MODE_REMOVE, 3'd0, 5'd0,  1'b0, 5'd0, ST_DONE},
      '{MODE_POP,    3'd0, 5'd0,  1'b0, 5'd0, ST_DONE},
      '{MODE_POP,    3'd0, 5'd0,  1'b0, 5'd0, ST_DONE},
      '{MODE_REMOVE, 3'd7, 5'd10, 1'b0, 5'd0, ST_DONE},
      '{MODE_POP,    3'd7, 5'd0,  1'b0, 5'd0, ST_DONE},
      '{MODE_POP,    3'd7, 5'd0,  1'b0, 5'd0, ST_DONE},
      '{MODE_APPEND, 3'd3, 5'd31, 1'b0, 5'd0, ST_DONE},
      '{MODE_REMOVE, 3'd3, 5'd31, 1'b0, 5'd0, ST_DONE},
      '{MODE_POP,    3'd3, 5'd0,  1'b0, 5'd0, ST_DONE},
      '{MODE_INSERT, 3'd3, 5'd7,  1'b0, 5'd0, ST_DONE},
      '{MODE_APPEND, 3'd3, 5'd0,  1'b0, 5'd0, ST_DONE}
    };
    sched_clear();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[i])
      send_item(dir_rows[i].m, dir_rows[i].l, dir_rows[i].s, dir_rows[i].typed,
                dir_rows[i].popped, dir_rows[i].st);
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: send_idle_pct = 0;
          1: send_idle_pct = 20;
          default: send_idle_pct = 50;
        endcase
      end
      if (i >= RAND_ITEMS - CALM_ITEMS) calm = 1'b1;
      pick_item(m, l, s);
      send_item(m, l, s, 1'b0, '0, ST_DONE);
    end
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : receiver
    int cyc;
    cyc = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: recv_idle_pct = 0;
          1: recv_idle_pct = 10;
          default: recv_idle_pct = 40;
        endcase
      end
      if (!hold_done && n_sent >= HOLD_AT) begin
        // long hold: the engine backs up and stalls its input
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(1, 100) <= recv_idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    sched_reply_t rep;
    if (!rst && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        $error("unexpected item: popped_slot %0d status %0d", popped_slot, status);
        errors++;
      end else begin
        rep = expected_replies.pop_front();
        if (popped_slot !== rep.popped) begin
          $error("popped_slot: expected %0d, got %0d", rep.popped, popped_slot);
          errors++;
        end
        if (status !== rep.st) begin
          $error("status: expected %0d, got %0d", rep.st, status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
